/* design/trs_pkg.sv */
package trs_pkg;

	// Sizing
	localparam int NUM_RUNWAYS  = 8;
	localparam int QUEUE_DEPTH  = 64;
	localparam int RW_W         = (NUM_RUNWAYS > 1) ? $clog2(NUM_RUNWAYS) : 1;
	localparam int RW_CNT_W     = $clog2(NUM_RUNWAYS + 1);
	localparam int QA_W         = $clog2(QUEUE_DEPTH);
	localparam int QC_W         = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ARR_W        = 4;
	localparam int ACT_W        = 4;
	localparam int SVC_W        = 8;
	localparam int ID_W         = 16;
	localparam int TIME_W       = 32;
	localparam int SUM_W        = 32;
	localparam int IDX_W        = 3;
	localparam int KIND_W       = 2;
	localparam int ENTRY_W      = ID_W + TIME_W;

	// Stream and config port widths
	localparam int IN_W         = 2 * ARR_W;
	localparam int OUT_FIELD_W  = ID_W + IDX_W + TIME_W + 5 * SUM_W + 2;
	localparam int OUT_DATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELD_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	// Reset values
	localparam logic [ACT_W-1:0] ACTIVE_RESET       = ACT_W'(8);
	localparam logic [SVC_W-1:0] SVC_RESET          = SVC_W'(1);
	localparam logic [ID_W-1:0]  FIRST_LANDING_NUM  = ID_W'(5001);
	localparam logic [ID_W-1:0]  FIRST_TAKEOFF_NUM  = ID_W'(1);
	localparam logic [TIME_W-1:0] SIM_TIME_RESET    = TIME_W'(1);

	typedef enum logic [KIND_W-1:0] {
		EV_LAND,
		EV_TAKEOFF,
		EV_FREE,
		EV_SUMMARY
	} ev_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE,
		CFG_LAND_SVC,
		CFG_TAKE_SVC
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_SAT_ADD,
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ_L,
		ST_ENQ_T,
		ST_SCAN,
		ST_POP,
		ST_BUSY,
		ST_WAIT,
		ST_DEC,
		ST_SUM
	} st_t;

	typedef struct packed {
		logic [ACT_W-1:0] active;
		logic [SVC_W-1:0] land_svc;
		logic [SVC_W-1:0] take_svc;
	} cfg_t;

	typedef struct packed {
		alu_op_t           op;
		logic [SUM_W-1:0]  a;
		logic [SUM_W-1:0]  b;
	} alu_req_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic [ID_W-1:0]   id;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] tick;
		logic [SUM_W-1:0]  busy;
		logic [SUM_W-1:0]  lwait;
		logic [SUM_W-1:0]  twait;
		logic [SUM_W-1:0]  ltotal;
		logic [SUM_W-1:0]  ttotal;
		logic              idle;
		logic              ovf;
		logic              last;
	} ev_t;

endpackage

/* design/two_class_runway_scheduler.sv */
// Two-class runway scheduler.
// Input stream: one transfer per time tick carrying the landing and takeoff
// arrival counts. Arrivals are numbered and stamped into two request queues;
// each free runway in the active set then takes the oldest landing, else the
// oldest takeoff. Output stream: one transfer per event, in order: assignments
// by runway, runway-freed events by runway, then the tick summary (tlast=1).
// Config channel: write registers 0 active runways, 1 landing service time,
// 2 takeoff service time, between ticks; cfg_ready is always high.
// The sequencer drives one shared 32-bit adder, one queue operation and one
// runway per cycle. s_axis_tready is high only between ticks. A stalled
// receiver holds the sequencer on the event waiting in the output register.
// Reset: queues empty, runways free, sums zero, time 1, landing numbers
// from 5001, takeoff numbers from 1, registers at 8 / 1 / 1.
module two_class_runway_scheduler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [3:0] landing_arrivals, [7:4] takeoff_arrivals
	input  logic [trs_pkg::IN_W-1:0]           s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] plane_id, [18:16] runway_index, [50:19] tick_time,
	// [82:51] runway_busy_total, [114:83] landing_wait_sum,
	// [146:115] takeoff_wait_sum, [178:147] landing_total,
	// [210:179] takeoff_total, [211] all_idle, [212] queue_overflow, rest zero
	output logic [trs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [1:0] event_kind
	output logic [trs_pkg::KIND_W-1:0]         m_axis_tuser,
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [trs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import trs_pkg::*;

	cfg_t cfg_q;
	ev_t  ev;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active   <= ACTIVE_RESET;
			cfg_q.land_svc <= SVC_RESET;
			cfg_q.take_svc <= SVC_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACTIVE:   cfg_q.active   <= cfg_data[ACT_W-1:0];
				CFG_LAND_SVC: cfg_q.land_svc <= cfg_data[SVC_W-1:0];
				CFG_TAKE_SVC: cfg_q.take_svc <= cfg_data[SVC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	trs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_land   (s_axis_tdata[ARR_W-1:0]),
		.in_take   (s_axis_tdata[IN_W-1:ARR_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ev    (ev)
	);

	// Result packing, first field in the low bits
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, ev.ovf, ev.idle, ev.ttotal, ev.ltotal,
		ev.twait, ev.lwait, ev.busy, ev.tick, ev.idx, ev.id};
	assign m_axis_tuser = ev.kind;
	assign m_axis_tlast = ev.last;

endmodule

/* design/trs_ram.sv */
module trs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/trs_alu.sv */
module trs_alu (
	input  trs_pkg::alu_req_t              req,
	output logic [trs_pkg::SUM_W-1:0]      res
);
	import trs_pkg::*;

	logic [SUM_W:0] sum;

	// Shared 32-bit adder: saturating add, wrapping add, wrapping subtract
	always_comb begin
		sum = {1'b0, req.a} + {1'b0, req.b};
		case (req.op)
			ALU_SAT_ADD: res = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
			ALU_ADD:     res = sum[SUM_W-1:0];
			ALU_SUB:     res = req.a - req.b;
			default:     res = sum[SUM_W-1:0];
		endcase
	end

endmodule

/* design/trs_ctrl.sv */
module trs_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  trs_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [trs_pkg::ARR_W-1:0]    in_land,
	input  logic [trs_pkg::ARR_W-1:0]    in_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output trs_pkg::ev_t                 out_ev
);
	import trs_pkg::*;

	st_t                 st_q, st_d;
	logic [ARR_W-1:0]    nl_q, nt_q;
	logic [RW_CNT_W-1:0] i_q;
	logic [RW_W-1:0]     rw;
	logic                cls_q, ovf_q, idle_q;
	logic [TIME_W-1:0]   wait_q, sim_q;
	logic [ID_W-1:0]     id_q, lnum_q, tnum_q;
	logic [QA_W-1:0]     lrd_q, lwr_q, trd_q, twr_q;
	logic [QC_W-1:0]     lcnt_q, tcnt_q;
	logic [SUM_W-1:0]    lw_q, tw_q, lt_q, tt_q;
	logic [SVC_W-1:0]    rem_q [NUM_RUNWAYS];
	logic [SUM_W-1:0]    busy_q [NUM_RUNWAYS];
	logic [RW_CNT_W-1:0] scan_lim;
	logic                scan_done, dec_done, dec_go;
	logic                out_free, l_full, t_full, rem_zero, rem_one;
	logic                l_we, t_we;
	logic [ENTRY_W-1:0]  l_rdata, t_rdata, pop_entry;
	logic [SVC_W-1:0]    svc;
	alu_req_t            alu_req;
	logic [SUM_W-1:0]    alu_res;
	ev_t                 ev_d, out_q;
	logic                ev_load, out_valid_q;

	function automatic logic [QA_W-1:0] ptr_next(input logic [QA_W-1:0] p);
		logic [QA_W-1:0] n;
		n = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	// Request queues: {id, time stamp}, stamp in the low bits
	trs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_land_q (
		.clk     (clk),
		.we      (l_we),
		.wr_addr (lwr_q),
		.wr_data ({lnum_q, sim_q}),
		.rd_addr (lrd_q),
		.rd_data (l_rdata)
	);

	trs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_take_q (
		.clk     (clk),
		.we      (t_we),
		.wr_addr (twr_q),
		.wr_data ({tnum_q, sim_q}),
		.rd_addr (trd_q),
		.rd_data (t_rdata)
	);

	trs_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// Status decode
	always_comb begin
		if (32'(cfg.active) > 32'(NUM_RUNWAYS)) begin
			scan_lim = RW_CNT_W'(NUM_RUNWAYS);
		end else begin
			scan_lim = RW_CNT_W'(cfg.active);
		end
	end

	assign rw        = i_q[RW_W-1:0];
	assign scan_done = (i_q >= scan_lim);
	assign dec_done  = (i_q == RW_CNT_W'(NUM_RUNWAYS));
	assign out_free  = !out_valid_q || out_ready;
	assign l_full    = (lcnt_q == QC_W'(QUEUE_DEPTH));
	assign t_full    = (tcnt_q == QC_W'(QUEUE_DEPTH));
	assign rem_zero  = (rem_q[rw] == '0);
	assign rem_one   = (rem_q[rw] == SVC_W'(1));
	assign dec_go    = !dec_done && (!rem_one || out_free);
	assign pop_entry = cls_q ? t_rdata : l_rdata;
	assign svc       = cls_q ? cfg.take_svc : cfg.land_svc;

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_valid) st_d = ST_ENQ_L;
			ST_ENQ_L: if (nl_q == '0) st_d = ST_ENQ_T;
			ST_ENQ_T: if (nt_q == '0) st_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					st_d = ST_DEC;
				end else if (rem_zero && (lcnt_q != '0 || tcnt_q != '0)) begin
					st_d = ST_POP;
				end
			end
			ST_POP:   st_d = ST_BUSY;
			ST_BUSY:  st_d = ST_WAIT;
			ST_WAIT:  if (out_free) st_d = ST_SCAN;
			ST_DEC:   if (dec_done) st_d = ST_SUM;
			ST_SUM:   if (out_free) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// Shared unit operands, queue writes and event build
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = sim_q;
		alu_req.b  = '0;
		l_we       = 1'b0;
		t_we       = 1'b0;
		ev_load    = 1'b0;
		ev_d       = '0;
		unique case (st_q)
			ST_ENQ_L: begin
				alu_req.op = ALU_SAT_ADD;
				alu_req.a  = lt_q;
				alu_req.b  = SUM_W'(1);
				l_we       = (nl_q != '0) && !l_full;
			end
			ST_ENQ_T: begin
				alu_req.op = ALU_SAT_ADD;
				alu_req.a  = tt_q;
				alu_req.b  = SUM_W'(1);
				t_we       = (nt_q != '0) && !t_full;
			end
			ST_POP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = sim_q;
				alu_req.b  = pop_entry[TIME_W-1:0];
			end
			ST_BUSY: begin
				alu_req.op = ALU_SAT_ADD;
				alu_req.a  = busy_q[rw];
				alu_req.b  = SUM_W'(svc);
			end
			ST_WAIT: begin
				alu_req.op = ALU_SAT_ADD;
				alu_req.a  = cls_q ? tw_q : lw_q;
				alu_req.b  = wait_q;
				ev_load    = out_free;
				ev_d.kind  = cls_q ? EV_TAKEOFF : EV_LAND;
				ev_d.id    = id_q;
				ev_d.idx   = IDX_W'(rw);
				ev_d.tick  = sim_q;
				ev_d.busy  = busy_q[rw];
			end
			ST_DEC: begin
				ev_load    = dec_go && rem_one;
				ev_d.kind  = EV_FREE;
				ev_d.idx   = IDX_W'(rw);
				ev_d.tick  = sim_q;
				ev_d.busy  = busy_q[rw];
			end
			ST_SUM: begin
				alu_req.b   = TIME_W'(1);
				ev_load     = out_free;
				ev_d.kind   = EV_SUMMARY;
				ev_d.tick   = sim_q;
				ev_d.lwait  = lw_q;
				ev_d.twait  = tw_q;
				ev_d.ltotal = lt_q;
				ev_d.ttotal = tt_q;
				ev_d.idle   = idle_q && (lcnt_q == '0) && (tcnt_q == '0);
				ev_d.ovf    = ovf_q;
				ev_d.last   = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer state and scheduler bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			nl_q   <= '0;
			nt_q   <= '0;
			i_q    <= '0;
			cls_q  <= 1'b0;
			ovf_q  <= 1'b0;
			idle_q <= 1'b1;
			wait_q <= '0;
			id_q   <= '0;
			sim_q  <= SIM_TIME_RESET;
			lnum_q <= FIRST_LANDING_NUM;
			tnum_q <= FIRST_TAKEOFF_NUM;
			lrd_q  <= '0;
			lwr_q  <= '0;
			lcnt_q <= '0;
			trd_q  <= '0;
			twr_q  <= '0;
			tcnt_q <= '0;
			lw_q   <= '0;
			tw_q   <= '0;
			lt_q   <= '0;
			tt_q   <= '0;
			for (int k = 0; k < NUM_RUNWAYS; k++) begin
				rem_q[k]  <= '0;
				busy_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						nl_q  <= in_land;
						nt_q  <= in_take;
						ovf_q <= 1'b0;
						i_q   <= '0;
					end
				end
				ST_ENQ_L: begin
					if (nl_q != '0) begin
						nl_q <= nl_q - 1'b1;
						if (l_full) begin
							ovf_q <= 1'b1;
						end else begin
							lwr_q  <= ptr_next(lwr_q);
							lcnt_q <= lcnt_q + 1'b1;
							lnum_q <= lnum_q + 1'b1;
							lt_q   <= alu_res;
						end
					end
				end
				ST_ENQ_T: begin
					if (nt_q != '0) begin
						nt_q <= nt_q - 1'b1;
						if (t_full) begin
							ovf_q <= 1'b1;
						end else begin
							twr_q  <= ptr_next(twr_q);
							tcnt_q <= tcnt_q + 1'b1;
							tnum_q <= tnum_q + 1'b1;
							tt_q   <= alu_res;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						i_q    <= '0;
						idle_q <= 1'b1;
					end else if (rem_zero && lcnt_q != '0) begin
						cls_q <= 1'b0;
					end else if (rem_zero && tcnt_q != '0) begin
						cls_q <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_POP: begin
					wait_q    <= alu_res;
					id_q      <= pop_entry[ENTRY_W-1:TIME_W];
					rem_q[rw] <= svc;
					if (cls_q) begin
						trd_q  <= ptr_next(trd_q);
						tcnt_q <= tcnt_q - 1'b1;
					end else begin
						lrd_q  <= ptr_next(lrd_q);
						lcnt_q <= lcnt_q - 1'b1;
					end
				end
				ST_BUSY: busy_q[rw] <= alu_res;
				ST_WAIT: begin
					if (out_free) begin
						if (cls_q) begin
							tw_q <= alu_res;
						end else begin
							lw_q <= alu_res;
						end
						i_q <= i_q + 1'b1;
					end
				end
				ST_DEC: begin
					if (dec_go) begin
						i_q <= i_q + 1'b1;
						if (!rem_zero) begin
							rem_q[rw] <= rem_q[rw] - 1'b1;
							if (!rem_one) begin
								idle_q <= 1'b0;
							end
						end
					end
				end
				ST_SUM: if (out_free) sim_q <= alu_res;
				default: ;
			endcase

			// Output register valid
			if (ev_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ev_load) begin
			out_q <= ev_d;
		end
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_ev    = out_q;

	// Empty queue has matching pointers
	a_land_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(lcnt_q == '0) |-> (lrd_q == lwr_q))
		else $error("landing queue empty with unequal pointers");

	a_take_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(tcnt_q == '0) |-> (trd_q == twr_q))
		else $error("takeoff queue empty with unequal pointers");

	// A pop only happens on a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP) |-> (cls_q ? (tcnt_q != '0) : (lcnt_q != '0)))
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lcnt_q <= QC_W'(QUEUE_DEPTH)) && (tcnt_q <= QC_W'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	// Only the summary closes a tick
	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last == (out_q.kind == EV_SUMMARY)))
		else $error("last flag does not match summary event");

endmodule
